/* hdl/ogpd_pkg.sv */
// Shared types and constants for the Ogg page demuxer.
// No dependencies; imported by the table loader, the top level and the testbench.
`timescale 1ns / 1ps

package ogpd_pkg;

    // Result status codes
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_BAD_CAPTURE = 3'd1;
    localparam logic [2:0] STAT_BAD_VERSION = 3'd2;
    localparam logic [2:0] STAT_TRUNCATED   = 3'd3;
    localparam logic [2:0] STAT_CLEAN_END   = 3'd4;

    // Page header byte positions
    localparam logic [4:0] POS_VERSION    = 5'd4;
    localparam logic [4:0] POS_FLAGS      = 5'd5;
    localparam logic [4:0] POS_GRAN_FIRST = 5'd6;
    localparam logic [4:0] POS_GRAN_LAST  = 5'd13;
    localparam logic [4:0] POS_SEQ_FIRST  = 5'd18;
    localparam logic [4:0] POS_SEQ_LAST   = 5'd21;
    localparam logic [4:0] POS_SEG_COUNT  = 5'd26;

    localparam logic [7:0] FULL_SEG = 8'd255;

    // "OggS"
    localparam logic [7:0] CAPTURE [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

    // Descriptor RAM write command from the table loader
    typedef struct packed {
        logic       lac_we;
        logic       run_we;
        logic [7:0] addr;
        logic [7:0] lac_data;
        logic [7:0] run_data;
    } seg_wr_t;

    // Table loader status seen by the control logic
    typedef struct packed {
        logic       last;       // current byte is the last table entry
        logic       have_nz;    // a nonzero segment is present, current byte included
        logic [7:0] lead_next;  // leading zero count, current byte included
        logic [7:0] nz_count;   // nonzero segments stored so far
    } tbl_stat_t;

endpackage

/* hdl/ogpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ogpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 255
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/ogpd_table_loader.sv */
// Segment table loader: compacts nonzero lacing values and their zero runs.
// Depends on ogpd_pkg; drives the descriptor RAM write port.
`timescale 1ns / 1ps

module ogpd_table_loader (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,      // segment count byte accepted
    input  logic               byte_en,    // table byte accepted
    input  logic [7:0]         in_byte,
    output ogpd_pkg::seg_wr_t  wr,
    output ogpd_pkg::tbl_stat_t stat
);
    import ogpd_pkg::*;

    logic [7:0] total_reg, total_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] nz_reg, nz_next;
    logic [7:0] lead_reg, lead_next;
    logic [7:0] run_reg, run_next;

    always_comb
    begin
        total_next = total_reg;
        idx_next   = idx_reg;
        nz_next    = nz_reg;
        lead_next  = lead_reg;
        run_next   = run_reg;
        wr         = '0;
        if (start)
        begin
            total_next = in_byte;
            idx_next   = '0;
            nz_next    = '0;
            lead_next  = '0;
            run_next   = '0;
        end
        else if (byte_en)
        begin
            idx_next = idx_reg + 8'd1;
            if (in_byte != 8'd0)
            begin
                // new descriptor, its run starts empty
                wr.lac_we   = 1'b1;
                wr.run_we   = 1'b1;
                wr.addr     = nz_reg;
                wr.lac_data = in_byte;
                wr.run_data = 8'd0;
                nz_next     = nz_reg + 8'd1;
                run_next    = 8'd0;
            end
            else if (nz_reg != 8'd0)
            begin
                // extend run of the last descriptor
                wr.run_we   = 1'b1;
                wr.addr     = nz_reg - 8'd1;
                wr.run_data = run_reg + 8'd1;
                run_next    = run_reg + 8'd1;
            end
            else
            begin
                lead_next = lead_reg + 8'd1;
            end
        end
    end

    always_comb
    begin
        stat.last      = (({1'b0, idx_reg} + 9'd1) == {1'b0, total_reg});
        stat.have_nz   = (nz_next != 8'd0);
        stat.lead_next = lead_next;
        stat.nz_count  = nz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            idx_reg   <= '0;
            nz_reg    <= '0;
            lead_reg  <= '0;
            run_reg   <= '0;
        end
        else
        begin
            total_reg <= total_next;
            idx_reg   <= idx_next;
            nz_reg    <= nz_next;
            lead_reg  <= lead_next;
            run_reg   <= run_next;
        end
    end

endmodule

/* hdl/ogg_page_packet_demuxer.sv */
// Ogg page demuxer top level: header parse, descriptor RAMs, body sequencer.
// Depends on ogpd_pkg, ogpd_ram, ogpd_table_loader.
// A result is registered and shows on out_valid in the cycle after the input transfer.
// Throughput: one byte per cycle in header, table and body while the result register is
// free; a page with body bytes holds in_ready low in LOAD_A and LOAD_B after its table
// (descriptor RAM read). Reset (rst_n, async low) returns to the start of a page
// header; the descriptor RAMs are not cleared.
`timescale 1ns / 1ps

module ogg_page_packet_demuxer #(
    parameter int MAX_SEGS = 255
) (
    input  logic               clk,
    input  logic               rst_n,
    // byte input
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               is_end,
    // result output
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         payload_byte,
    output logic               byte_valid,
    output logic               packet_end,
    output logic [7:0]         empty_packets,
    output logic signed [63:0] granule,
    output logic [31:0]        page_seq_num,
    output logic [2:0]         page_flags,
    output logic [2:0]         status
);
    import ogpd_pkg::*;

    localparam int AW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;

    // LOAD_A issues the read of descriptor 0, LOAD_B latches it and
    // issues descriptor 1, so the body can start at one byte per cycle while results drain.
    typedef enum logic [5:0] {
        S_HEADER = 6'b000001,
        S_TABLE  = 6'b000010,
        S_LOAD_A = 6'b000100,
        S_LOAD_B = 6'b001000,
        S_DATA   = 6'b010000,
        S_HALT   = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  hpos_reg, hpos_next;
    logic [2:0]  flags_reg, flags_next;
    logic [63:0] gran_reg, gran_next;
    logic [31:0] seq_reg, seq_next;
    logic        open_reg, open_next;
    logic [7:0]  k_reg, k_next;          // current descriptor (compacted index)
    logic [7:0]  left_reg, left_next;    // bytes left in current segment
    logic [7:0]  size_reg, size_next;
    logic [7:0]  run_reg, run_next;

    // output register
    logic        out_valid_reg;
    logic [7:0]  pay_reg;
    logic        bval_reg;
    logic        pend_reg;
    logic [7:0]  empty_reg;
    logic [63:0] ogran_reg;
    logic [31:0] oseq_reg;
    logic [2:0]  oflags_reg;
    logic [2:0]  ostat_reg;

    logic        accept;
    logic        can_take;
    logic        res_fire;
    logic [7:0]  res_byte;
    logic        res_bval;
    logic        res_pend;
    logic [7:0]  res_empty;
    logic [2:0]  res_stat;
    logic        tbl_start;
    logic        tbl_byte;
    logic [7:0]  tbl_empty;
    logic        tbl_pend;
    logic [4:0]  goff;
    logic [4:0]  soff;
    logic [7:0]  rd_idx;

    seg_wr_t     wr;
    tbl_stat_t   tbl_st;
    logic [7:0]  lac_rdata;
    logic [7:0]  run_rdata;

    ogpd_table_loader u_loader (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (tbl_start),
        .byte_en (tbl_byte),
        .in_byte (in_byte),
        .wr      (wr),
        .stat    (tbl_st)
    );

    // Descriptor memories, one entry per nonzero segment in table order
    ogpd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SEGS)
    ) u_lacing_ram (
        .clk   (clk),
        .we    (wr.lac_we),
        .waddr (wr.addr[AW-1:0]),
        .wdata (wr.lac_data),
        .raddr (rd_idx[AW-1:0]),
        .rdata (lac_rdata)
    );

    ogpd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SEGS)
    ) u_zero_run_ram (
        .clk   (clk),
        .we    (wr.run_we),
        .waddr (wr.addr[AW-1:0]),
        .wdata (wr.run_data),
        .raddr (rd_idx[AW-1:0]),
        .rdata (run_rdata)
    );

    // A halted block swallows everything; LOAD states wait on the RAM.
    assign can_take = !out_valid_reg || out_ready;
    always_comb
    begin
        if (state_reg == S_HALT)
        begin
            in_ready = 1'b1;
        end
        else if (state_reg == S_LOAD_A || state_reg == S_LOAD_B)
        begin
            in_ready = 1'b0;
        end
        else
        begin
            in_ready = can_take;
        end
    end
    assign accept = in_valid && in_ready;

    assign goff = hpos_reg - POS_GRAN_FIRST;
    assign soff = hpos_reg - POS_SEQ_FIRST;

    // Read one descriptor ahead of the one in use; the read address follows
    // the next-state index so a one-byte segment still finds its successor.
    assign rd_idx = (state_reg == S_LOAD_A) ? 8'd0 : (k_next + 8'd1);

    // Table end: a leading zero segment first closes a packet left open
    always_comb
    begin
        tbl_pend  = 1'b0;
        tbl_empty = tbl_st.lead_next;
        if (tbl_st.lead_next != 8'd0 && open_reg)
        begin
            tbl_pend  = 1'b1;
            tbl_empty = tbl_st.lead_next - 8'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hpos_next  = hpos_reg;
        flags_next = flags_reg;
        gran_next  = gran_reg;
        seq_next   = seq_reg;
        open_next  = open_reg;
        k_next     = k_reg;
        left_next  = left_reg;
        size_next  = size_reg;
        run_next   = run_reg;
        res_fire   = 1'b0;
        res_byte   = 8'd0;
        res_bval   = 1'b0;
        res_pend   = 1'b0;
        res_empty  = 8'd0;
        res_stat   = STAT_OK;
        tbl_start  = 1'b0;
        tbl_byte   = 1'b0;

        if (accept && is_end && state_reg != S_HALT)
        begin
            // end of file: clean only at a page boundary
            res_fire   = 1'b1;
            res_pend   = open_reg;
            res_stat   = (state_reg == S_HEADER && hpos_reg == 5'd0) ?
                         STAT_CLEAN_END : STAT_TRUNCATED;
            open_next  = 1'b0;
            state_next = S_HALT;
        end
        else
        begin
            unique case (state_reg)
                S_HEADER:
                begin
                    if (accept)
                    begin
                        hpos_next = hpos_reg + 5'd1;
                        if (hpos_reg < POS_VERSION)
                        begin
                            if (in_byte != CAPTURE[hpos_reg[1:0]])
                            begin
                                res_fire   = 1'b1;
                                res_pend   = open_reg;
                                res_stat   = STAT_BAD_CAPTURE;
                                open_next  = 1'b0;
                                state_next = S_HALT;
                            end
                        end
                        else if (hpos_reg == POS_VERSION)
                        begin
                            if (in_byte != 8'd0)
                            begin
                                res_fire   = 1'b1;
                                res_pend   = open_reg;
                                res_stat   = STAT_BAD_VERSION;
                                open_next  = 1'b0;
                                state_next = S_HALT;
                            end
                        end
                        else if (hpos_reg == POS_FLAGS)
                        begin
                            flags_next = in_byte[2:0];
                        end
                        else if (hpos_reg >= POS_GRAN_FIRST && hpos_reg <= POS_GRAN_LAST)
                        begin
                            gran_next[{goff[2:0], 3'b000} +: 8] = in_byte;
                        end
                        else if (hpos_reg >= POS_SEQ_FIRST && hpos_reg <= POS_SEQ_LAST)
                        begin
                            seq_next[{soff[1:0], 3'b000} +: 8] = in_byte;
                        end
                        else if (hpos_reg >= POS_SEG_COUNT)
                        begin
                            hpos_next = 5'd0;
                            if (in_byte > 8'(MAX_SEGS))
                            begin
                                // more segments than the descriptor RAM holds
                                res_fire   = 1'b1;
                                res_pend   = open_reg;
                                res_stat   = STAT_BAD_VERSION;
                                open_next  = 1'b0;
                                state_next = S_HALT;
                            end
                            else if (in_byte != 8'd0)
                            begin
                                tbl_start  = 1'b1;
                                state_next = S_TABLE;
                            end
                        end
                    end
                end

                S_TABLE:
                begin
                    if (accept)
                    begin
                        tbl_byte = 1'b1;
                        if (tbl_st.last)
                        begin
                            if (tbl_pend)
                            begin
                                open_next = 1'b0;
                            end
                            res_fire  = tbl_pend || (tbl_empty != 8'd0);
                            res_pend  = tbl_pend;
                            res_empty = tbl_empty;
                            k_next    = 8'd0;
                            state_next = tbl_st.have_nz ? S_LOAD_A : S_HEADER;
                        end
                    end
                end

                S_LOAD_A:
                begin
                    state_next = S_LOAD_B;
                end

                S_LOAD_B:
                begin
                    size_next  = lac_rdata;
                    run_next   = run_rdata;
                    left_next  = lac_rdata;
                    state_next = S_DATA;
                end

                S_DATA:
                begin
                    if (accept)
                    begin
                        res_fire  = 1'b1;
                        res_byte  = in_byte;
                        res_bval  = 1'b1;
                        open_next = 1'b1;
                        left_next = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            // segment done: a short segment, or a full one
                            // followed by zero-length segments, ends the packet
                            if (size_reg != FULL_SEG)
                            begin
                                res_pend  = 1'b1;
                                res_empty = run_reg;
                                open_next = 1'b0;
                            end
                            else if (run_reg != 8'd0)
                            begin
                                res_pend  = 1'b1;
                                res_empty = run_reg - 8'd1;
                                open_next = 1'b0;
                            end
                            if (({1'b0, k_reg} + 9'd1) >= {1'b0, tbl_st.nz_count})
                            begin
                                state_next = S_HEADER;
                            end
                            else
                            begin
                                k_next    = k_reg + 8'd1;
                                size_next = lac_rdata;
                                run_next  = run_rdata;
                                left_next = lac_rdata;
                            end
                        end
                    end
                end

                S_HALT:
                begin
                    state_next = S_HALT;
                end

                default:
                begin
                    state_next = S_HALT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HEADER;
            hpos_reg  <= '0;
            flags_reg <= '0;
            gran_reg  <= '0;
            seq_reg   <= '0;
            open_reg  <= 1'b0;
            k_reg     <= '0;
            left_reg  <= '0;
            size_reg  <= '0;
            run_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hpos_reg  <= hpos_next;
            flags_reg <= flags_next;
            gran_reg  <= gran_next;
            seq_reg   <= seq_next;
            open_reg  <= open_next;
            k_reg     <= k_next;
            left_reg  <= left_next;
            size_reg  <= size_next;
            run_reg   <= run_next;
        end
    end

    // Output register; page fields are captured with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            pay_reg    <= res_byte;
            bval_reg   <= res_bval;
            pend_reg   <= res_pend;
            empty_reg  <= res_empty;
            ogran_reg  <= gran_reg;
            oseq_reg   <= seq_reg;
            oflags_reg <= flags_reg;
            ostat_reg  <= res_stat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = pay_reg;
    assign byte_valid    = bval_reg;
    assign packet_end    = pend_reg;
    assign empty_packets = empty_reg;
    assign granule       = $signed(ogran_reg);
    assign page_seq_num  = oseq_reg;
    assign page_flags    = oflags_reg;
    assign status        = ostat_reg;

    // Any error or end result leaves the block halted
    a_halt_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res_stat != STAT_OK) |=> (state_reg == S_HALT))
        else $error("terminating result did not halt");

    // Halted block produces nothing
    a_quiet_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HALT) |-> !res_fire)
        else $error("result while halted");

    // Body always has a live segment within the stored descriptors
    a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> (left_reg != 8'd0 && k_reg < tbl_st.nz_count))
        else $error("body state outside stored descriptors");

    // Result register is never overwritten while still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !res_fire)
        else $error("pending result overwritten");

endmodule

/* sim/ogg_page_packet_demuxer_tb.sv */
// Self-checking testbench for the Ogg page demuxer: directed and random Ogg pages in,
// payload bytes and packet boundaries checked against an in-bench page/lacing predictor.
// Depends on ogpd_pkg and ogg_page_packet_demuxer (hdl/).
`timescale 1ns / 1ps

module ogg_page_packet_demuxer_tb;

    import ogpd_pkg::*;

    localparam int MAX_SEGS    = 255;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 50;

    // Idle profiles for the two channels
    localparam logic [1:0] MODE_STEADY   = 2'd0;
    localparam logic [1:0] MODE_TX_IDLE  = 2'd1;
    localparam logic [1:0] MODE_RX_STALL = 2'd2;
    localparam logic [1:0] MODE_BOTH     = 2'd3;

    // Ways the stream ends (only one per run, the block halts until reset)
    localparam int END_CLEAN       = 0;
    localparam int END_TRUNC_ANY   = 1;
    localparam int END_TRUNC_HDR   = 2;
    localparam int END_BAD_CAPTURE = 3;
    localparam int END_BAD_VERSION = 4;

    typedef enum logic [1:0] {IN_HEADER, IN_TABLE, IN_BODY} stage_t;

    // One byte of the file plus how it is to be sent
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic [1:0] mode;
        logic       drain;   // wait for all results before offering this byte
        logic       hold;    // start a long receiver hold when this byte transfers
    } item_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        valid;
        logic        pend;
        logic [7:0]  empties;
        logic [63:0] gpos;
        logic [31:0] pseq;
        logic [2:0]  flags;
        logic [2:0]  stat;
    } demux_out_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [7:0]         in_byte   = 8'h00;
    logic               is_end    = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         payload_byte;
    logic               byte_valid;
    logic               packet_end;
    logic [7:0]         empty_packets;
    logic signed [63:0] granule;
    logic [31:0]        page_seq_num;
    logic [2:0]         page_flags;
    logic [2:0]         status;

    item_t      file_q[$];      // file bytes still to be sent
    demux_out_t demuxed_q[$];   // demuxed results still to come out
    logic [7:0] page_buf[$];    // page under construction
    logic [7:0] seg_buf[$];     // its lacing values

    logic [1:0] fill_mode  = MODE_STEADY;
    logic [1:0] rx_mode    = MODE_STEADY;
    logic       hold_req   = 1'b0;
    int         hold_cnt   = 0;
    int         mismatches = 0;

    // Predictor state: page header, segment table and body position
    stage_t      stage         = IN_HEADER;
    logic [4:0]  hdr_pos       = 5'd0;
    logic [2:0]  pg_flags      = 3'd0;
    logic [63:0] pg_granule    = 64'd0;
    logic [31:0] pg_seq        = 32'd0;
    logic [7:0]  seg_count     = 8'd0;
    logic [7:0]  lace_len [256] = '{default: 8'd0};
    logic [7:0]  zero_run [256] = '{default: 8'd0};
    logic [7:0]  seg_ptr       = 8'd0;
    logic [7:0]  left_in_seg   = 8'd0;
    logic [7:0]  lead_zero_cnt = 8'd0;
    logic [7:0]  last_nz_idx   = 8'd0;
    logic        seen_nz       = 1'b0;
    logic        open_pkt      = 1'b0;
    logic        stopped       = 1'b0;

    ogg_page_packet_demuxer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .is_end        (is_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .byte_valid    (byte_valid),
        .packet_end    (packet_end),
        .empty_packets (empty_packets),
        .granule       (granule),
        .page_seq_num  (page_seq_num),
        .page_flags    (page_flags),
        .status        (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic demux_out_t page_result(input logic [7:0] d, input logic v,
                                               input logic pe, input logic [7:0] ep,
                                               input logic [2:0] st);
        demux_out_t r;
        r.data    = d;
        r.valid   = v;
        r.pend    = pe;
        r.empties = ep;
        r.gpos    = pg_granule;
        r.pseq    = pg_seq;
        r.flags   = pg_flags;
        r.stat    = st;
        return r;
    endfunction

    // Advance the predictor by one file byte; has is set when a result comes out.
    task automatic demux_byte(input logic [7:0] b, input logic eos,
                              output bit has, output demux_out_t r);
        int unsigned j;
        int unsigned i;
        int unsigned run;
        int unsigned nxt;
        logic        pend;
        logic [7:0]  empties;
        bit          stop;
        logic [2:0]  stop_code;
        has = 1'b0;
        r = '0;
        stop = 1'b0;
        stop_code = STAT_OK;
        if (stopped)
            return;
        if (eos)
        begin
            stop = 1'b1;
            stop_code = (stage == IN_HEADER && hdr_pos == 5'd0) ? STAT_CLEAN_END : STAT_TRUNCATED;
        end
        else if (stage == IN_HEADER)
        begin
            if (hdr_pos == POS_SEG_COUNT)
            begin
                if (int'(b) > MAX_SEGS)
                begin
                    stop = 1'b1;
                    stop_code = STAT_BAD_VERSION;
                end
                else if (b == 8'd0)
                    hdr_pos = 5'd0;     // empty page: straight on to the next header
                else
                begin
                    seg_count = b;
                    seg_ptr = 8'd0;
                    lead_zero_cnt = 8'd0;
                    seen_nz = 1'b0;
                    last_nz_idx = 8'd0;
                    stage = IN_TABLE;
                end
            end
            else
            begin
                if (hdr_pos < POS_VERSION)
                begin
                    if (b != CAPTURE[hdr_pos[1:0]])
                    begin
                        stop = 1'b1;
                        stop_code = STAT_BAD_CAPTURE;
                    end
                end
                else if (hdr_pos == POS_VERSION)
                begin
                    if (b != 8'h00)
                    begin
                        stop = 1'b1;
                        stop_code = STAT_BAD_VERSION;
                    end
                end
                else if (hdr_pos == POS_FLAGS)
                    pg_flags = b[2:0];
                else if (hdr_pos >= POS_GRAN_FIRST && hdr_pos <= POS_GRAN_LAST)
                    pg_granule[int'(hdr_pos - POS_GRAN_FIRST) * 8 +: 8] = b;
                else if (hdr_pos >= POS_SEQ_FIRST && hdr_pos <= POS_SEQ_LAST)
                    pg_seq[int'(hdr_pos - POS_SEQ_FIRST) * 8 +: 8] = b;
                if (!stop)
                    hdr_pos = hdr_pos + 5'd1;
            end
        end
        else if (stage == IN_TABLE)
        begin
            j = seg_ptr;
            lace_len[j] = b;
            zero_run[j] = 8'd0;
            // zero segments fold into the run count of the last nonzero one
            if (b == 8'd0)
            begin
                if (seen_nz)
                    zero_run[last_nz_idx] = zero_run[last_nz_idx] + 8'd1;
                else
                    lead_zero_cnt = lead_zero_cnt + 8'd1;
            end
            else
            begin
                last_nz_idx = 8'(j);
                seen_nz = 1'b1;
            end
            seg_ptr = 8'(j + 1);
            if (j + 1 >= seg_count)
            begin
                pend = 1'b0;
                empties = lead_zero_cnt;
                // a leading zero first closes a packet carried over from earlier pages
                if (lead_zero_cnt != 8'd0 && open_pkt)
                begin
                    pend = 1'b1;
                    empties = lead_zero_cnt - 8'd1;
                    open_pkt = 1'b0;
                end
                if (seen_nz)
                begin
                    stage = IN_BODY;
                    seg_ptr = lead_zero_cnt;
                    left_in_seg = lace_len[lead_zero_cnt];
                end
                else
                begin
                    stage = IN_HEADER;
                    hdr_pos = 5'd0;
                end
                if (pend || empties != 8'd0)
                begin
                    has = 1'b1;
                    r = page_result(8'h00, 1'b0, pend, empties, STAT_OK);
                end
            end
        end
        else
        begin
            i = seg_ptr;
            pend = 1'b0;
            empties = 8'd0;
            open_pkt = 1'b1;
            left_in_seg = left_in_seg - 8'd1;
            if (left_in_seg == 8'd0)
            begin
                run = zero_run[i];
                nxt = i + 1 + run;
                if (lace_len[i] == FULL_SEG)
                begin
                    // full segment continues the packet unless zeros follow
                    if (run > 0)
                    begin
                        pend = 1'b1;
                        empties = 8'(run - 1);
                        open_pkt = 1'b0;
                    end
                end
                else
                begin
                    pend = 1'b1;
                    empties = 8'(run);
                    open_pkt = 1'b0;
                end
                if (nxt >= seg_count)
                begin
                    stage = IN_HEADER;
                    hdr_pos = 5'd0;
                end
                else
                begin
                    seg_ptr = 8'(nxt);
                    left_in_seg = lace_len[nxt];
                end
            end
            has = 1'b1;
            r = page_result(b, 1'b1, pend, empties, STAT_OK);
        end
        if (stop)
        begin
            r = page_result(8'h00, 1'b0, open_pkt, 8'h00, stop_code);
            open_pkt = 1'b0;
            stopped = 1'b1;
            has = 1'b1;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    // Page from seg_buf with random serial, CRC and body bytes
    task automatic build_page(input logic [7:0] flag_byte, input logic [63:0] gpos,
                              input logic [31:0] pseq);
        int unsigned body_len;
        page_buf.delete();
        for (int k = 0; k < 4; k++)
            page_buf.push_back(CAPTURE[k]);
        page_buf.push_back(8'h00);
        page_buf.push_back(flag_byte);
        for (int k = 0; k < 8; k++)
            page_buf.push_back(gpos[k * 8 +: 8]);
        for (int k = 0; k < 4; k++)
            page_buf.push_back(8'($urandom));
        for (int k = 0; k < 4; k++)
            page_buf.push_back(pseq[k * 8 +: 8]);
        for (int k = 0; k < 4; k++)
            page_buf.push_back(8'($urandom));
        page_buf.push_back(8'(seg_buf.size()));
        body_len = 0;
        foreach (seg_buf[k])
        begin
            page_buf.push_back(seg_buf[k]);
            body_len += seg_buf[k];
        end
        repeat (body_len)
            page_buf.push_back(8'($urandom));
    endtask

    function automatic logic [7:0] pick_lacing();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 30)
            return 8'd0;
        if (p < 38)
            return FULL_SEG;
        if (p < 92)
            return 8'($urandom_range(16, 1));
        return 8'($urandom_range(254, 17));
    endfunction

    task automatic rand_page();
        int unsigned nseg;
        int unsigned p;
        logic [63:0] gpos;
        seg_buf.delete();
        p = $urandom_range(99);
        if (p < 6)
            nseg = 0;
        else if (p < 90)
            nseg = $urandom_range(6, 1);
        else
            nseg = $urandom_range(24, 7);
        repeat (nseg)
            seg_buf.push_back(pick_lacing());
        gpos = {$urandom, $urandom};
        p = $urandom_range(9);
        if (p == 0)
            gpos = 64'hFFFF_FFFF_FFFF_FFFF;
        else if (p == 1)
            gpos = 64'h8000_0000_0000_0000;
        else if (p == 2)
            gpos = 64'd0;
        build_page(8'($urandom), gpos, $urandom);
    endtask

    task automatic queue_page(input bit drain, input bit hold, input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            file_q.push_back('{data: page_buf[k], eos: 1'b0, mode: fill_mode,
                               drain: drain && k == 0, hold: hold && k == 0});
    endtask

    task automatic queue_marker(input bit drain, input logic eos);
        file_q.push_back('{data: 8'($urandom), eos: eos, mode: fill_mode,
                           drain: drain, hold: 1'b0});
    endtask

    // Stimulus: directed pages, random pages in four idle profiles, one way of ending
    initial
    begin : stimulus
        int unsigned rand_items;
        int unsigned kind;
        int unsigned cut;
        int unsigned k;
        fill_mode = MODE_STEADY;

        // leading zeros with nothing open, a full segment closed by a zero run, all flag bits
        seg_buf = {8'd0, 8'd0, 8'd3, 8'd255, 8'd0, 8'd0, 8'd255, 8'd5, 8'd0};
        build_page(8'hFF, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF);
        queue_page(1'b0, 1'b0, page_buf.size());
        // packet left open across the page end
        seg_buf = {8'd255};
        build_page(8'h00, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0000_0000);
        queue_page(1'b0, 1'b0, page_buf.size());
        // leading zero closes it, the second zero is an empty packet
        seg_buf = {8'd0, 8'd0, 8'd7};
        build_page(8'h01, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0001);
        queue_page(1'b0, 1'b0, page_buf.size());
        // open again, then continued by a short segment on the next page
        seg_buf = {8'd255};
        build_page(8'h00, 64'd0, 32'h8000_0000);
        queue_page(1'b0, 1'b0, page_buf.size());
        seg_buf = {8'd4};
        build_page(8'h05, 64'd1, 32'h8000_0001);
        queue_page(1'b0, 1'b0, page_buf.size());
        // page with no segments
        seg_buf.delete();
        build_page(8'h02, 64'h0123_4567_89AB_CDEF, 32'h5A5A_A5A5);
        queue_page(1'b0, 1'b0, page_buf.size());
        // full segment ended by a single zero
        seg_buf = {8'd255, 8'd0};
        build_page(8'h04, 64'hFEDC_BA98_7654_3210, 32'hA5A5_5A5A);
        queue_page(1'b0, 1'b0, page_buf.size());
        // most segments: all empty, then all one byte
        seg_buf.delete();
        repeat (MAX_SEGS)
            seg_buf.push_back(8'd0);
        build_page(8'h03, 64'd2, 32'd2);
        queue_page(1'b0, 1'b0, page_buf.size());
        seg_buf.delete();
        repeat (MAX_SEGS)
            seg_buf.push_back(8'd1);
        build_page(8'h06, 64'd3, 32'd3);
        queue_page(1'b0, 1'b0, page_buf.size());

        // long receiver hold while the sender keeps offering, then a full drain
        seg_buf = {8'd60};
        build_page(8'h00, 64'd4, 32'd4);
        queue_page(1'b0, 1'b1, page_buf.size());
        rand_page();
        queue_page(1'b1, 1'b0, page_buf.size());

        rand_items = 0;
        while (rand_items < 800)
        begin
            fill_mode = 2'((rand_items / 200) % 4);
            rand_page();
            queue_page($urandom_range(9) == 0, 1'b0, page_buf.size());
            rand_items += page_buf.size();
        end

        // end of stream; the block halts, later bytes must be swallowed silently
        fill_mode = 2'($urandom_range(3));
        rand_page();
        kind = $urandom_range(END_BAD_VERSION, END_CLEAN);
        case (kind)
            END_CLEAN:
                queue_marker(1'b1, 1'b1);
            END_TRUNC_ANY:
            begin
                cut = $urandom_range(page_buf.size() - 1, 1);
                queue_page(1'b1, 1'b0, cut);
                queue_marker(1'b0, 1'b1);
            end
            END_TRUNC_HDR:
            begin
                cut = $urandom_range(int'(POS_SEG_COUNT), 1);
                queue_page(1'b1, 1'b0, cut);
                queue_marker(1'b0, 1'b1);
            end
            END_BAD_CAPTURE:
            begin
                k = $urandom_range(3);
                page_buf[k] = page_buf[k] ^ 8'($urandom_range(255, 1));
                queue_page(1'b1, 1'b0, page_buf.size());
            end
            default:
            begin
                page_buf[POS_VERSION] = 8'($urandom_range(255, 1));
                queue_page(1'b1, 1'b0, page_buf.size());
            end
        endcase
        repeat (8)
            queue_marker(1'b0, 1'($urandom));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (file_q.size() != 0 || in_valid)
            @(posedge clk);
        for (int n = 0; n < 5000 && demuxed_q.size() != 0; n++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (demuxed_q.size() != 0)
            flag_mismatch("results never delivered", 64'(demuxed_q.size()), 64'd0);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Driver: presents the head of file_q, predicts each transfer as it happens
    always @(posedge clk or negedge rst_n)
    begin : drive
        item_t      head;
        demux_out_t res;
        bit         has_res;
        bit         gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            is_end   <= 1'b0;
            hold_req <= 1'b0;
            rx_mode  <= MODE_STEADY;
        end
        else
        begin
            hold_req <= in_valid && in_ready && file_q.size() != 0 && file_q[0].hold;
            if (in_valid && in_ready)
            begin
                head = file_q.pop_front();
                rx_mode <= head.mode;
                demux_byte(in_byte, is_end, has_res, res);
                if (has_res)
                    demuxed_q.push_back(res);
            end
            // offer the next byte unless one is still waiting for its transfer
            if (!in_valid || in_ready)
            begin
                gap = 1'b1;
                if (file_q.size() != 0 && !(file_q[0].drain && demuxed_q.size() != 0))
                begin
                    head = file_q[0];
                    case (head.mode)
                        MODE_TX_IDLE: gap = $urandom_range(99) < 66;
                        MODE_BOTH:    gap = $urandom_range(99) < 17;
                        default:      gap = 1'b0;
                    endcase
                end
                in_valid <= !gap;
                if (!gap)
                begin
                    in_byte <= head.data;
                    is_end  <= head.eos;
                end
            end
        end
    end

    // Long receiver hold, counted apart from the random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_req)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // Monitor: checks every result transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch
        demux_out_t want;
        bit         stall;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (demuxed_q.size() == 0)
                    flag_mismatch("result with none pending", 64'(payload_byte), 64'd0);
                else
                begin
                    want = demuxed_q.pop_front();
                    if (payload_byte !== want.data)
                        flag_mismatch("payload_byte", 64'(payload_byte), 64'(want.data));
                    if (byte_valid !== want.valid)
                        flag_mismatch("byte_valid", 64'(byte_valid), 64'(want.valid));
                    if (packet_end !== want.pend)
                        flag_mismatch("packet_end", 64'(packet_end), 64'(want.pend));
                    if (empty_packets !== want.empties)
                        flag_mismatch("empty_packets", 64'(empty_packets), 64'(want.empties));
                    if (granule !== want.gpos)
                        flag_mismatch("granule", granule, want.gpos);
                    if (page_seq_num !== want.pseq)
                        flag_mismatch("page_seq_num", 64'(page_seq_num), 64'(want.pseq));
                    if (page_flags !== want.flags)
                        flag_mismatch("page_flags", 64'(page_flags), 64'(want.flags));
                    if (status !== want.stat)
                        flag_mismatch("status", 64'(status), 64'(want.stat));
                end
            end
            case (rx_mode)
                MODE_RX_STALL: stall = $urandom_range(99) < 66;
                MODE_BOTH:     stall = $urandom_range(99) < 17;
                default:       stall = 1'b0;
            endcase
            out_ready <= (hold_cnt == 0) && !stall;
        end
    end

endmodule
